@@ rtl/cal_pkg.sv @@
// package: types, constants and sizes shared by the array list block
package cal_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W      = 32;
    localparam int CAP_W       = 5;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CAP_W-1:0]         cap_t;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_EDIT   = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_DUMP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        status_t status;
        word_t   entry_value;
        addr_t   entry_position;
        cnt_t    entry_count;
        logic    last;
    } res_t;

endpackage

@@ rtl/cal_in_if.sv @@
// interface: operation request channel
interface cal_in_if;
    import cal_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode;
    addr_t index;
    word_t value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink (input valid, input mode, input index, input value, output ready);
endinterface

@@ rtl/cal_out_if.sv @@
// interface: result channel
interface cal_out_if;
    import cal_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    word_t   entry_value;
    addr_t   entry_position;
    cnt_t    entry_count;
    logic    last;

    modport source (output valid, output status, output entry_value, output entry_position,
                    output entry_count, output last, input ready);
    modport sink (input valid, input status, input entry_value, input entry_position,
                  input entry_count, input last, output ready);
endinterface

@@ rtl/cal_ram.sv @@
// generic simple dual-port ram with registered read
module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/cal_ctrl.sv @@
// sequencer: operation decode, entry count, delete shift and dump walk over the entry ram
module cal_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    cal_in_if.sink        in_ch,
    input  cal_pkg::cap_t capacity,
    input  logic          out_free,
    output logic          res_load,
    output cal_pkg::res_t res
);
    import cal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DEL  = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    addr_t  ptr_reg, ptr_next;

    logic  ram_we, ram_re;
    addr_t ram_waddr, ram_raddr;
    word_t ram_wdata, ram_rdata;

    cnt_t eff_cap;
    cnt_t idx_ext;
    cnt_t ptr_ext;
    logic accept;

    cal_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign eff_cap = (CNT_W'(capacity) > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                            : CNT_W'(capacity);
    assign idx_ext = CNT_W'(in_ch.index);
    assign ptr_ext = CNT_W'(ptr_reg);
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        ram_we     = 1'b0;
        ram_waddr  = in_ch.index;
        ram_wdata  = in_ch.value;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        res_load   = 1'b0;
        res.status         = ST_OK;
        res.entry_value    = '0;
        res.entry_position = '0;
        res.entry_count    = count_reg;
        res.last           = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.mode)
                        MODE_APPEND:
                        begin
                            res_load = 1'b1;
                            if (count_reg >= eff_cap || count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = count_reg[ADDR_W-1:0];
                                count_next      = count_reg + 1'b1;
                                res.entry_count = count_reg + 1'b1;
                            end
                        end
                        MODE_EDIT:
                        begin
                            res_load = 1'b1;
                            if (idx_ext >= count_reg)
                            begin
                                res.status = ST_BADIDX;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else if (idx_ext >= count_reg)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_BADIDX;
                            end
                            else if (idx_ext + 1'b1 < count_reg)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = in_ch.index + 1'b1;
                                ptr_next   = in_ch.index + 1'b1;
                                state_next = S_DEL;
                            end
                            else
                            begin
                                res_load        = 1'b1;
                                count_next      = count_reg - 1'b1;
                                res.entry_count = count_reg - 1'b1;
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b0;
                        end
                    endcase
                end
            end
            S_DEL:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (ptr_ext + 1'b1 < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    res_load        = 1'b1;
                    count_next      = count_reg - 1'b1;
                    res.entry_count = count_reg - 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP:
            begin
                res.entry_value    = ram_rdata;
                res.entry_position = ptr_reg;
                res.last           = (ptr_ext + 1'b1 == count_reg);
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (res.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg + 1'b1;
                        ptr_next  = ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end
endmodule

@@ rtl/compacting_array_list.sv @@
// top level: fixed-capacity array list with capacity register and output register
//
// Keeps up to 16 signed 32-bit words in a single dual-port ram and takes one
// operation per transfer on in_ch. Append, edit, every failed operation, a
// delete of the last entry and a dump of an empty list give one result from
// idle. Delete at index i of n entries moves each later entry down through
// the ram, one read and one write per cycle. Dump of n entries emits one
// result per cycle while out_ch takes them, with last on the final one. The
// ram's registered read and single read port set this pace. A result waits
// in the output register; while out_ch holds it back, in_ch takes no new
// transfer and a dump does not advance. The capacity register resets to 16.
// The user writes it with cfg_wr_en only while the block is idle (unchecked).
module compacting_array_list (
    input  logic          clk,
    input  logic          rst_n,
    cal_in_if.sink        in_ch,
    cal_out_if.source     out_ch,
    input  logic          cfg_wr_en,
    input  cal_pkg::cap_t cfg_wr_data
);
    import cal_pkg::*;

    cap_t capacity_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    logic out_free;
    logic res_load;
    res_t res;

    assign out_free = !out_valid_reg || out_ch.ready;

    cal_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .capacity(capacity_reg),
        .out_free(out_free),
        .res_load(res_load),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_W'(MAX_ENTRIES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_res_reg.status;
    assign out_ch.entry_value    = out_res_reg.entry_value;
    assign out_ch.entry_position = out_res_reg.entry_position;
    assign out_ch.entry_count    = out_res_reg.entry_count;
    assign out_ch.last           = out_res_reg.last;
endmodule

@@ tb/tb.sv @@
// testbench: directed and random operations on the array list, checked by a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cal_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 20;
    localparam int PHASE_COUNT  = 7;

    typedef struct {
        mode_t   mode;
        addr_t   index;
        word_t   value;
        logic    fixed;
        status_t want_status;
        cnt_t    want_count;
    } op_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cap_t cfg_wr_data;

    cal_in_if  in_ch();
    cal_out_if out_ch();

    compacting_array_list uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predicted list contents
    word_t   list_words [MAX_ENTRIES];
    int      list_count;
    cap_t    list_capacity;
    res_t    expected_results [$];
    op_row_t directed_ops [$];

    logic    idle_on;
    int      stall_left;
    int      error_count;
    int      ops_sent;
    int      results_checked;
    int      peak_count;
    res_t    want_res;

    always #5 clk = ~clk;

    function automatic res_t make_res(status_t s, word_t v, addr_t p, cnt_t c, logic l);
        res_t r;
        r.status         = s;
        r.entry_value    = v;
        r.entry_position = p;
        r.entry_count    = c;
        r.last           = l;
        return r;
    endfunction

    function automatic op_row_t row(mode_t m, addr_t ix, word_t v, logic fixed,
                                    status_t s, cnt_t c);
        op_row_t r;
        r.mode        = m;
        r.index       = ix;
        r.value       = v;
        r.fixed       = fixed;
        r.want_status = s;
        r.want_count  = c;
        return r;
    endfunction

    function automatic void predict_list_op(mode_t m, addr_t ix, word_t v);
        int lim;
        lim = (list_capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(list_capacity);
        case (m)
            MODE_APPEND:
            begin
                if (list_count >= lim || list_count >= MAX_ENTRIES)
                begin
                    expected_results.push_back(make_res(ST_FULL, '0, '0, cnt_t'(list_count), 1'b1));
                end
                else
                begin
                    list_words[list_count] = v;
                    list_count++;
                    expected_results.push_back(make_res(ST_OK, '0, '0, cnt_t'(list_count), 1'b1));
                end
            end
            MODE_EDIT:
            begin
                if (int'(ix) >= list_count)
                begin
                    expected_results.push_back(make_res(ST_BADIDX, '0, '0, cnt_t'(list_count), 1'b1));
                end
                else
                begin
                    list_words[ix] = v;
                    expected_results.push_back(make_res(ST_OK, '0, '0, cnt_t'(list_count), 1'b1));
                end
            end
            MODE_DELETE:
            begin
                if (list_count == 0)
                begin
                    expected_results.push_back(make_res(ST_EMPTY, '0, '0, '0, 1'b1));
                end
                else if (int'(ix) >= list_count)
                begin
                    expected_results.push_back(make_res(ST_BADIDX, '0, '0, cnt_t'(list_count), 1'b1));
                end
                else
                begin
                    for (int i = int'(ix); i + 1 < list_count; i++)
                    begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_count--;
                    expected_results.push_back(make_res(ST_OK, '0, '0, cnt_t'(list_count), 1'b1));
                end
            end
            default:
            begin
                if (list_count == 0)
                begin
                    expected_results.push_back(make_res(ST_EMPTY, '0, '0, '0, 1'b1));
                end
                else
                begin
                    for (int i = 0; i < list_count; i++)
                    begin
                        expected_results.push_back(make_res(ST_OK, list_words[i], addr_t'(i),
                                                            cnt_t'(list_count),
                                                            (i + 1 == list_count)));
                    end
                end
            end
        endcase
        if (list_count > peak_count)
        begin
            peak_count = list_count;
        end
    endfunction

    // called just after a rising edge; returns at the edge of the transfer with valid still high
    task automatic send_op(op_row_t op);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_list_op(op.mode, op.index, op.value);
        if (op.fixed)
        begin
            void'(expected_results.pop_back());
            expected_results.push_back(make_res(op.want_status, '0, '0, op.want_count, 1'b1));
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= op.mode;
        in_ch.index <= op.index;
        in_ch.value <= op.value;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        ops_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic set_capacity(cap_t c);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        list_capacity = c;
    endtask

    task automatic random_op(int append_pct);
        op_row_t op;
        op.fixed       = 1'b0;
        op.want_status = ST_OK;
        op.want_count  = '0;
        if ($urandom_range(0, 99) < append_pct)
        begin
            op.mode = MODE_APPEND;
        end
        else
        begin
            op.mode = mode_t'($urandom_range(1, 3));
        end
        if (list_count > 0 && $urandom_range(0, 3) != 0)
        begin
            op.index = addr_t'($urandom_range(0, list_count - 1));
        end
        else
        begin
            op.index = addr_t'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 7))
            0: op.value = 32'h7fff_ffff;
            1: op.value = 32'h8000_0000;
            2: op.value = '0;
            default: op.value = $urandom();
        endcase
        send_op(op);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // output stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d value %0h",
                         $time, out_ch.status, out_ch.entry_value);
                error_count++;
            end
            else
            begin
                want_res = expected_results.pop_front();
                check_field("status", want_res.status, out_ch.status);
                check_field("entry_value", want_res.entry_value, out_ch.entry_value);
                check_field("entry_position", want_res.entry_position, out_ch.entry_position);
                check_field("entry_count", want_res.entry_count, out_ch.entry_count);
                check_field("last", want_res.last, out_ch.last);
                results_checked++;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        cap_t phase_caps [PHASE_COUNT];
        int   phase_len [PHASE_COUNT];
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_ch.valid  = 1'b0;
        in_ch.mode   = MODE_APPEND;
        in_ch.index  = '0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        idle_on      = 1'b1;
        stall_left   = 0;
        error_count  = 0;
        ops_sent     = 0;
        results_checked = 0;
        peak_count   = 0;
        list_count   = 0;
        list_capacity = 5'd16;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            list_words[i] = '0;
        end

        phase_caps = '{5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd2, 5'd16};
        phase_len  = '{22, 10, 8, 10, 10, 8, 10};

        directed_ops.push_back(row(MODE_DUMP,   4'd0,  32'h0,         1'b1, ST_EMPTY,  5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd0,  32'h0,         1'b1, ST_EMPTY,  5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd15, 32'h0,         1'b1, ST_EMPTY,  5'd0));
        directed_ops.push_back(row(MODE_EDIT,   4'd0,  32'h1,         1'b1, ST_BADIDX, 5'd0));
        directed_ops.push_back(row(MODE_APPEND, 4'd0,  32'h7fff_ffff, 1'b1, ST_OK,     5'd1));
        directed_ops.push_back(row(MODE_APPEND, 4'd15, 32'h8000_0000, 1'b1, ST_OK,     5'd2));
        directed_ops.push_back(row(MODE_APPEND, 4'd0,  32'hffff_ffff, 1'b1, ST_OK,     5'd3));
        directed_ops.push_back(row(MODE_EDIT,   4'd3,  32'h5,         1'b1, ST_BADIDX, 5'd3));
        directed_ops.push_back(row(MODE_EDIT,   4'd15, 32'h5,         1'b1, ST_BADIDX, 5'd3));
        directed_ops.push_back(row(MODE_DELETE, 4'd3,  32'h0,         1'b1, ST_BADIDX, 5'd3));
        directed_ops.push_back(row(MODE_DUMP,   4'd15, 32'hffff_ffff, 1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_EDIT,   4'd1,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_APPEND, 4'd0,  32'h5555_5555, 1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_APPEND, 4'd0,  32'haaaa_aaaa, 1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DUMP,   4'd0,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd0,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DUMP,   4'd0,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd3,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_EDIT,   4'd0,  32'h1234_5678, 1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DUMP,   4'd0,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd1,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd0,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd0,  32'h0,         1'b0, ST_OK,     5'd0));
        directed_ops.push_back(row(MODE_DELETE, 4'd0,  32'h0,         1'b1, ST_EMPTY,  5'd0));
        directed_ops.push_back(row(MODE_DUMP,   4'd0,  32'h0,         1'b1, ST_EMPTY,  5'd0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
        begin
            send_op(directed_ops[i]);
        end

        // random phases, each under its own capacity; the first is weighted towards appends
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == PHASE_COUNT - 1)
            begin
                idle_on = 1'b0;
            end
            set_capacity(phase_caps[p]);
            for (int n = 0; n < phase_len[p]; n++)
            begin
                random_op((p == 0) ? 85 : 40);
            end
        end

        drain_results();

        $display("tb: %0d operations sent, %0d results checked, list filled up to %0d entries",
                 ops_sent, results_checked, peak_count);
        $display("tb: capacities 16, 31, 1, 0, 7, 2 used, with append, edit, delete and dump");
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cal_pkg.sv
rtl/cal_in_if.sv
rtl/cal_out_if.sv
rtl/cal_ram.sv
rtl/cal_ctrl.sv
rtl/compacting_array_list.sv
tb/tb.sv
